[hdl/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the LRU frame replacement block.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int FRAME_W       = 6;   // width of a frame number on the ports
    localparam int CFG_W         = 7;   // width of the frames_in_use register
    localparam int RESET_FRAMES  = 64;  // frames_in_use after reset
    localparam int RESULT_W      = 16;

    // Result item, hit in the lowest bit
    typedef struct packed {
        logic               index_error;
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_valid;
        logic [FRAME_W-1:0] replaced_frame;
        logic               replaced;
        logic               hit;
    } lfr_result_t;

endpackage

[hdl/lfr_lru_matrix.sv]
// ----------------------------------------------------------------------------
// lfr_lru_matrix
// Recency matrix, resident set and fill count, with the one-pass update and
// the LRU search on both the current and the updated state.
// ----------------------------------------------------------------------------
module lfr_lru_matrix
    import lfr_pkg::*;
#(
    parameter int MAX_FRAMES = 64,
    parameter int CMP_W      = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear_i,
    input  logic               step_i,
    input  logic [FRAME_W-1:0] frame_i,
    input  logic [CMP_W-1:0]   limit_i,
    output lfr_result_t        result_o
);

    localparam int IDX_W  = $clog2(MAX_FRAMES);
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int WIDE_W = (IDX_W > FRAME_W) ? IDX_W : FRAME_W;

    logic [MAX_FRAMES-1:0] row_reg  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] row_next [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] res_reg, res_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic [WIDE_W-1:0]     frame_wide;
    logic [IDX_W-1:0]      f_idx;
    logic [MAX_FRAMES-1:0] f_bit;
    logic                  err, is_res, full, hit, insert, evict;

    logic [MAX_FRAMES-1:0] newer_cur, cand_cur, lru_cur;
    logic [MAX_FRAMES-1:0] newer_nxt, cand_nxt, lru_nxt;
    logic [MAX_FRAMES-1:0] m_cur, m_nxt;
    logic [IDX_W-1:0]      lru_cur_idx, lru_nxt_idx;
    logic [WIDE_W-1:0]     lru_cur_wide, lru_nxt_wide;
    logic                  replaced, victim_valid;

    assign frame_wide = WIDE_W'(frame_i);
    assign f_idx      = frame_wide[IDX_W-1:0];
    assign f_bit      = MAX_FRAMES'(1) << f_idx;

    assign err    = CMP_W'(frame_i) >= limit_i;
    assign is_res = res_reg[f_idx];
    assign full   = CMP_W'(count_reg) >= limit_i;
    assign hit    = !err && is_res;
    assign insert = !err && !is_res && !full;
    assign evict  = !err && !is_res && full;

    // LRU on the current state: resident and newer than no other resident
    always_comb begin
        m_cur = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            m_cur        = row_reg[i] & res_reg;
            m_cur[i]     = 1'b0;
            newer_cur[i] = |m_cur;
        end
    end

    assign cand_cur = res_reg & ~newer_cur;
    assign lru_cur  = cand_cur & (~cand_cur + MAX_FRAMES'(1));
    assign replaced = evict && (|cand_cur);

    // State after this item
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (err) begin
                row_next[i] = row_reg[i];
            end else if (IDX_W'(i) == f_idx) begin
                row_next[i] = ~f_bit;
            end else begin
                row_next[i] = row_reg[i] & ~f_bit;
            end
        end
        if (err) begin
            res_next = res_reg;
        end else if (replaced) begin
            res_next = (res_reg & ~lru_cur) | f_bit;
        end else begin
            res_next = res_reg | f_bit;
        end
        count_next = insert ? count_reg + CNT_W'(1) : count_reg;
    end

    // LRU on the updated state
    always_comb begin
        m_nxt = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            m_nxt        = row_next[i] & res_next;
            m_nxt[i]     = 1'b0;
            newer_nxt[i] = |m_nxt;
        end
    end

    assign cand_nxt = res_next & ~newer_nxt;
    assign lru_nxt  = cand_nxt & (~cand_nxt + MAX_FRAMES'(1));
    assign victim_valid = (CMP_W'(count_next) >= limit_i) && (|cand_nxt);

    always_comb begin
        lru_cur_idx = '0;
        lru_nxt_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            lru_cur_idx = lru_cur_idx | (lru_cur[i] ? IDX_W'(i) : '0);
            lru_nxt_idx = lru_nxt_idx | (lru_nxt[i] ? IDX_W'(i) : '0);
        end
    end

    assign lru_cur_wide = WIDE_W'(lru_cur_idx);
    assign lru_nxt_wide = WIDE_W'(lru_nxt_idx);

    always_comb begin
        result_o.hit            = hit;
        result_o.replaced       = replaced;
        result_o.replaced_frame = replaced ? lru_cur_wide[FRAME_W-1:0] : '0;
        result_o.victim_valid   = victim_valid;
        result_o.victim_frame   = victim_valid ? lru_nxt_wide[FRAME_W-1:0] : '0;
        result_o.index_error    = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_i) begin
            res_reg   <= '0;
            count_reg <= '0;
        end else if (step_i) begin
            res_reg   <= res_next;
            count_reg <= count_next;
        end
    end

    // Rows of frames that are not resident are masked, so no reset is needed
    always_ff @(posedge aclk) begin
        if (step_i) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(res_reg) == int'(count_reg))
        else $error("fill count does not match resident set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= limit_i)
        else $error("more frames resident than the limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_i && hit && !clear_i) |=> res_reg == $past(res_reg))
        else $error("resident set changed on a hit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_i && !err && !clear_i) |=> res_reg[$past(f_idx)])
        else $error("referenced frame not resident after update");

endmodule

[hdl/lru_frame_replacement.sv]
// ----------------------------------------------------------------------------
// lru_frame_replacement
// Exact LRU replacement over the page frames in use, one reference per item.
// ----------------------------------------------------------------------------
//  channel   direction  ports                         content
//  s_        in         s_tvalid s_tready s_tdata     frame_index
//  m_        out        m_tvalid m_tready m_tdata     hit, replacement, victim
//  cfg_      in         cfg_wr_en cfg_wr_data         frames_in_use
//
//  One item per clock while m_tready is high; an item passes through the input
//  register, then one update pass over the recency matrix into the result
//  register, before it reaches m_.
//  Reset and any frames_in_use write clear the resident set.
//  With m_tready low the result holds and one more item waits in the input
//  register before s_tready drops.
// ----------------------------------------------------------------------------
module lru_frame_replacement
    import lfr_pkg::*;
#(
    parameter int MAX_FRAMES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,   // frames_in_use
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,       // [5:0] frame_index
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata        // [0] hit, [1] replaced,
                                               // [7:2] replaced_frame,
                                               // [8] victim_valid,
                                               // [14:9] victim_frame,
                                               // [15] index_error
);

    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int RESET_LIMIT = (MAX_FRAMES < RESET_FRAMES) ? MAX_FRAMES : RESET_FRAMES;

    logic               in_valid_reg;
    logic [FRAME_W-1:0] in_frame_reg;
    logic               out_valid_reg;
    lfr_result_t        out_result_reg;
    logic [CMP_W-1:0]   limit_reg, limit_next;
    logic [CMP_W-1:0]   cfg_wide;
    logic               advance;
    lfr_result_t        result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;

    // Clamp the written limit to 1..MAX_FRAMES
    always_comb begin
        cfg_wide = CMP_W'(cfg_wr_data);
        if (cfg_wide == '0) begin
            limit_next = CMP_W'(1);
        end else if (cfg_wide > CMP_W'(MAX_FRAMES)) begin
            limit_next = CMP_W'(MAX_FRAMES);
        end else begin
            limit_next = cfg_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= CMP_W'(RESET_LIMIT);
        end else if (cfg_wr_en) begin
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_frame_reg <= s_tdata[FRAME_W-1:0];
        end
    end

    lfr_lru_matrix #(
        .MAX_FRAMES (MAX_FRAMES),
        .CMP_W      (CMP_W)
    ) u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear_i  (cfg_wr_en),
        .step_i   (advance),
        .frame_i  (in_frame_reg),
        .limit_i  (limit_reg),
        .result_o (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

endmodule

[sim/lru_frame_replacement_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacement_test
// Self-checking bench for the LRU frame replacement block. A recency list
// (least recent first) follows every accepted reference and predicts each
// result item; results are compared field by field in order. The run covers
// several frame limits, random idling on both channels and a long result stall.
// ----------------------------------------------------------------------------
import lfr_pkg::*;

class lru_scoreboard;
    int unsigned      max_frames;
    int unsigned      frame_limit;
    bit [FRAME_W-1:0] recency_q[$];     // resident frames, least recent first
    lfr_result_t      expected_q[$];
    int unsigned      mismatches;
    int unsigned      refs_checked;
    int unsigned      hits_checked;
    int unsigned      errors_checked;
    int unsigned      full_checked;
    int unsigned      drops_checked;

    function new(int unsigned max_frames_in);
        max_frames     = max_frames_in;
        mismatches     = 0;
        refs_checked   = 0;
        hits_checked   = 0;
        errors_checked = 0;
        full_checked   = 0;
        drops_checked  = 0;
        set_frames_in_use(RESET_FRAMES);
    endfunction

    // Clamp the limit and clear the resident set, as any register write does
    function void set_frames_in_use(int unsigned value);
        if (value == 0) begin
            frame_limit = 1;
        end else if (value > max_frames) begin
            frame_limit = max_frames;
        end else begin
            frame_limit = value;
        end
        recency_q.delete();
    endfunction

    function void note_reference(bit [FRAME_W-1:0] frame);
        lfr_result_t want;
        int          pos;
        want = '0;
        pos  = -1;
        if (frame >= frame_limit) begin
            want.index_error = 1'b1;
        end else begin
            foreach (recency_q[i]) begin
                if (recency_q[i] == frame) pos = i;
            end
            if (pos >= 0) begin
                want.hit = 1'b1;
                recency_q.delete(pos);
            end else if (recency_q.size() >= frame_limit) begin
                want.replaced       = 1'b1;
                want.replaced_frame = recency_q.pop_front();
            end
            recency_q.push_back(frame);
        end
        if (recency_q.size() >= frame_limit) begin
            want.victim_valid = 1'b1;
            want.victim_frame = recency_q[0];
        end
        expected_q.push_back(want);
    endfunction

    task report(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(logic [RESULT_W-1:0] data);
        lfr_result_t got;
        lfr_result_t want;
        got = data;
        if (expected_q.size() == 0) begin
            report($sformatf("result %h with no reference outstanding", data));
            return;
        end
        want = expected_q.pop_front();
        refs_checked++;
        if (want.hit) hits_checked++;
        if (want.index_error) errors_checked++;
        if (want.victim_valid) full_checked++;
        if (want.replaced) drops_checked++;
        compare_field("hit", 8'(got.hit), 8'(want.hit));
        compare_field("replaced", 8'(got.replaced), 8'(want.replaced));
        compare_field("replaced_frame", 8'(got.replaced_frame), 8'(want.replaced_frame));
        compare_field("victim_valid", 8'(got.victim_valid), 8'(want.victim_valid));
        compare_field("victim_frame", 8'(got.victim_frame), 8'(want.victim_frame));
        compare_field("index_error", 8'(got.index_error), 8'(want.index_error));
    endtask
endclass

module lru_frame_replacement_test;

    localparam int MAX_FRAMES  = 64;
    localparam int HALF_PERIOD = 2;
    localparam int PIPE_CYCLES = 4;     // covers the input and result registers
    localparam int N_PHASES    = 12;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = '0;   // [5:0] frame_index
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [RESULT_W-1:0] m_tdata;            // hit, replaced, replaced_frame,
                                             // victim_valid, victim_frame,
                                             // index_error

    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_idle_pct  = 0;
    logic          hold_results   = 1'b0;
    int            phase_no       = -1;
    int unsigned   limits_written = 0;
    lru_scoreboard sb             = new(MAX_FRAMES);

    lru_frame_replacement #(
        .MAX_FRAMES (MAX_FRAMES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold off results long enough for the block to fill and stall its input
    initial begin
        wait (phase_no == 2);
        @(posedge aclk);
        hold_results <= 1'b1;
        repeat (80) @(posedge aclk);
        hold_results <= 1'b0;
    end

    task automatic send_frame(bit [FRAME_W-1:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 8'(frame);
        do @(posedge aclk); while (!s_tready);
        sb.note_reference(frame);
    endtask

    task automatic wait_drained(int unsigned cap);
        int unsigned n = 0;
        while (sb.expected_q.size() != 0 && n < cap) begin
            @(posedge aclk);
            n++;
        end
    endtask

    task automatic write_frames_in_use(bit [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained(20000);
        repeat (PIPE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_frames_in_use(value);
        limits_written++;
    endtask

    // Mostly sweep and revisit frames below the limit to fill the table,
    // with some references at the limit and across the whole index range
    task automatic run_phase(int unsigned n_items);
        int unsigned      sweep;
        int unsigned      pick;
        bit [FRAME_W-1:0] frame;
        sweep = $urandom_range(sb.frame_limit - 1);
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                frame = FRAME_W'(sweep);
                sweep = (sweep + 1) % sb.frame_limit;
            end else if (pick < 85) begin
                frame = FRAME_W'($urandom_range(sb.frame_limit - 1));
            end else if (pick < 92 && sb.frame_limit < MAX_FRAMES) begin
                frame = FRAME_W'(sb.frame_limit);
            end else begin
                frame = FRAME_W'($urandom_range(MAX_FRAMES - 1));
            end
            send_frame(frame);
        end
    endtask

    initial begin
        bit [CFG_W-1:0] limits [N_PHASES];
        limits = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd8, 7'd127,
                   7'd65, 7'd33, 7'd0, 7'd0, 7'd64, 7'd0};
        limits[9]  = CFG_W'($urandom_range(4, 127));
        limits[11] = CFG_W'($urandom_range(1, 127));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit: lowest and highest frames, then hits on both
        send_frame(6'd0);
        send_frame(6'd63);
        send_frame(6'd0);
        send_frame(6'd63);
        // limit of zero acts as one frame: full at once, then bad indexes
        write_frames_in_use(7'd0);
        send_frame(6'd0);
        send_frame(6'd0);
        send_frame(6'd1);
        send_frame(6'd63);
        // two frames: bad index at the limit, fill, then recency swaps
        write_frames_in_use(7'd2);
        send_frame(6'd1);
        send_frame(6'd1);
        send_frame(6'd2);
        send_frame(6'd0);
        send_frame(6'd1);
        // limits above the frame count clamp to the maximum
        write_frames_in_use(7'd127);
        send_frame(6'd63);
        send_frame(6'd0);
        write_frames_in_use(7'd65);
        send_frame(6'd63);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p / 4)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_frames_in_use(limits[p]);
            phase_no = p;
            run_phase(75 + sb.frame_limit);
        end

        s_tvalid <= 1'b0;
        wait_drained(20000);
        repeat (PIPE_CYCLES * 4) @(posedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

        $display("checked %0d references over %0d frame limits: %0d hits, %0d bad indexes",
                 sb.refs_checked, limits_written, sb.hits_checked, sb.errors_checked);
        $display("table full after %0d references, %0d frames dropped, %0d mismatches",
                 sb.full_checked, sb.drops_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.expected_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
